/* hdl/terminfo_padding_parser_core_macros.svh */
// Assertion macros for the terminal padding parser core.
// No dependencies; included by the core, the only file that carries concurrent assertions.
`ifndef TERMINFO_PADDING_PARSER_CORE_MACROS_SVH
`define TERMINFO_PADDING_PARSER_CORE_MACROS_SVH

// Overlapping implication, checked on the rising clock edge outside reset
`define TPP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tpp assertion failed");

// Implication checked in the cycle after the antecedent
`define TPP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tpp assertion failed");

`endif

/* hdl/tpp_pkg.sv */
// Package for the terminal padding parser core: widths, character codes,
// parse mode codes, register indexes, result type and helpers. No dependencies.
package tpp_pkg;

    // Width of the internal delay accumulator
    localparam int DELAY_BITS = 24;
    localparam int OUT_BITS   = 24;

    typedef logic [DELAY_BITS-1:0] delay_t;
    localparam delay_t DELAY_MAX = {DELAY_BITS{1'b1}};

    // Character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_OPEN   = 8'h3C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam int         TEN       = 10;

    // Parse mode codes
    localparam logic [2:0] M_NORMAL = 3'd0;
    localparam logic [2:0] M_DOLLAR = 3'd1;
    localparam logic [2:0] M_OPEN   = 3'd2;
    localparam logic [2:0] M_INT    = 3'd3;
    localparam logic [2:0] M_FRAC   = 3'd4;
    localparam logic [2:0] M_SKIP   = 3'd5;
    localparam logic [2:0] M_MOD    = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] CFG_AFFECTED = 3'd0;
    localparam logic [2:0] CFG_FLOW     = 3'd1;
    localparam logic [2:0] CFG_RATE     = 3'd2;
    localparam logic [2:0] CFG_BAUD     = 3'd3;
    localparam logic [2:0] CFG_NOSCREEN = 3'd4;

    // One result item
    typedef struct packed {
        logic                kind;
        logic [7:0]          out_char;
        logic [OUT_BITS-1:0] delay_tenths;
        logic                last_of_run;
        logic                end_of_string;
    } res_t;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_DELAY = 1'b1;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic res_t byte_res(input logic [7:0] c);
        res_t r;
        r = '0;
        r.kind = KIND_BYTE;
        r.out_char = c;
        return r;
    endfunction

    // Delay result, clamped to the output field width
    function automatic res_t delay_res(input delay_t d);
        res_t        r;
        logic [31:0] ext;
        r = '0;
        ext = 32'(d);
        r.kind = KIND_DELAY;
        r.delay_tenths = (ext > 32'(2**OUT_BITS - 1)) ? {OUT_BITS{1'b1}}
                                                      : ext[OUT_BITS-1:0];
        return r;
    endfunction

endpackage

/* hdl/terminfo_padding_parser_core.sv */
// Terminal padding parser core: passes control-string bytes through and turns
// padding specs into delay requests. The first result is presented in the cycle after accept.
// One item per cycle while items give at most one result and m_tready is high; an item
// with several results holds the three-entry result buffer until its last result is taken.
// Reset (aresetn low, synchronous): registers to defaults, normal text, buffer empty.
// Depends on tpp_pkg and terminfo_padding_parser_core_macros.svh.
`include "terminfo_padding_parser_core_macros.svh"

module terminfo_padding_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_char
    input  logic        s_tuser,   // closer_ahead
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_char, [31:8] delay_tenths
    output logic        m_tlast,   // last_of_run
    output logic [1:0]  m_tuser,   // [0] kind, [1] end_of_string
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [21:0] cfg_data
);

    localparam int DB = tpp_pkg::DELAY_BITS;
    localparam int MW = DB + 10;

    // Configuration registers
    logic [9:0]  affected_reg;
    logic        flow_reg;
    logic [21:0] rate_reg;
    logic [21:0] baud_reg;
    logic        noscreen_reg;

    // Parser state
    logic [2:0]      mode_reg, mode_next;
    tpp_pkg::delay_t delay_reg, delay_next;
    logic            mand_reg, mand_next;

    // Result buffer, head in entry 0
    tpp_pkg::res_t res_reg [3];
    tpp_pkg::res_t res_next [3];
    logic [1:0]    cnt_reg, cnt_next;

    logic       s_accept, m_pop;
    logic [7:0] c;
    logic [3:0] digit;
    logic [MW-1:0] prod_mul, prod_int, sum_frac;
    tpp_pkg::delay_t sat_mul, sat_int, sat_frac, sat_first;

    assign cfg_ready = 1'b1;
    assign c         = s_tdata;
    assign digit     = s_tdata[3:0];

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_pop    = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign s_accept = s_tvalid && s_tready;

    assign m_tdata  = {res_reg[0].delay_tenths, res_reg[0].out_char};
    assign m_tlast  = res_reg[0].last_of_run;
    assign m_tuser  = {res_reg[0].end_of_string, res_reg[0].kind};

    // Delay arithmetic, each saturated at the accumulator width
    assign prod_mul = MW'(delay_reg) * MW'(affected_reg);
    assign prod_int = MW'(delay_reg) * MW'(tpp_pkg::TEN) + MW'(digit) * MW'(tpp_pkg::TEN);
    assign sum_frac = MW'(delay_reg) + MW'(digit);
    assign sat_mul  = (prod_mul > MW'(tpp_pkg::DELAY_MAX)) ? tpp_pkg::DELAY_MAX
                                                           : prod_mul[DB-1:0];
    assign sat_int  = (prod_int > MW'(tpp_pkg::DELAY_MAX)) ? tpp_pkg::DELAY_MAX
                                                           : prod_int[DB-1:0];
    assign sat_frac = (sum_frac > MW'(tpp_pkg::DELAY_MAX)) ? tpp_pkg::DELAY_MAX
                                                           : sum_frac[DB-1:0];
    assign sat_first = DB'(digit) * DB'(tpp_pkg::TEN);

    // Whether a finished spec gives a delay result
    function automatic logic spec_fires(input tpp_pkg::delay_t d, input logic m,
                                        input logic [21:0] rate, input logic [21:0] baud,
                                        input logic nos);
        return m && (d != '0) && (rate != 22'd0) && (nos || (baud >= rate));
    endfunction

    // Next state and results of the item on the input
    always_comb begin
        logic fin;
        fin = 1'b0;
        mode_next  = mode_reg;
        delay_next = delay_reg;
        mand_next  = mand_reg;
        cnt_next   = 2'd0;
        for (int k = 0; k < 3; k++) begin
            res_next[k] = '0;
        end

        unique case (mode_reg) inside
            tpp_pkg::M_DOLLAR: begin
                if (c == tpp_pkg::CH_OPEN && !s_tlast) begin
                    mode_next = tpp_pkg::M_OPEN;
                end else begin
                    res_next[0] = tpp_pkg::byte_res(tpp_pkg::CH_DOLLAR);
                    res_next[1] = tpp_pkg::byte_res(c);
                    cnt_next    = 2'd2;
                    mode_next   = tpp_pkg::M_NORMAL;
                end
            end
            tpp_pkg::M_OPEN: begin
                if ((!tpp_pkg::is_digit(c) && c != tpp_pkg::CH_DOT) || !s_tuser) begin
                    // bad spec start: emit the opener, then the byte as text or a new escape
                    res_next[0] = tpp_pkg::byte_res(tpp_pkg::CH_DOLLAR);
                    res_next[1] = tpp_pkg::byte_res(tpp_pkg::CH_OPEN);
                    mode_next   = tpp_pkg::M_NORMAL;
                    if (c == tpp_pkg::CH_DOLLAR && !s_tlast) begin
                        mode_next = tpp_pkg::M_DOLLAR;
                        cnt_next  = 2'd2;
                    end else begin
                        res_next[2] = tpp_pkg::byte_res(c);
                        cnt_next    = 2'd3;
                    end
                end else begin
                    mand_next = !flow_reg;
                    if (c == tpp_pkg::CH_DOT) begin
                        delay_next = '0;
                        mode_next  = tpp_pkg::M_FRAC;
                    end else begin
                        delay_next = sat_first;
                        mode_next  = tpp_pkg::M_INT;
                    end
                end
            end
            tpp_pkg::M_INT, tpp_pkg::M_FRAC, tpp_pkg::M_SKIP, tpp_pkg::M_MOD: begin
                if (mode_reg == tpp_pkg::M_INT && tpp_pkg::is_digit(c)) begin
                    delay_next = sat_int;
                end else if (mode_reg == tpp_pkg::M_INT && c == tpp_pkg::CH_DOT) begin
                    mode_next = tpp_pkg::M_FRAC;
                end else if (mode_reg == tpp_pkg::M_FRAC && tpp_pkg::is_digit(c)) begin
                    delay_next = sat_frac;
                    mode_next  = tpp_pkg::M_SKIP;
                end else if (mode_reg == tpp_pkg::M_SKIP && tpp_pkg::is_digit(c)) begin
                    mode_next = tpp_pkg::M_SKIP;
                end else if (c == tpp_pkg::CH_STAR) begin
                    delay_next = sat_mul;
                    mode_next  = tpp_pkg::M_MOD;
                end else if (c == tpp_pkg::CH_SLASH) begin
                    mand_next = 1'b1;
                    mode_next = tpp_pkg::M_MOD;
                end else begin
                    // terminating byte: consumed, spec finished
                    if (spec_fires(delay_reg, mand_reg, rate_reg, baud_reg, noscreen_reg)) begin
                        res_next[0] = tpp_pkg::delay_res(delay_reg);
                        cnt_next    = 2'd1;
                    end
                    delay_next = '0;
                    mand_next  = 1'b0;
                    mode_next  = tpp_pkg::M_NORMAL;
                end
            end
            default: begin
                mode_next = tpp_pkg::M_NORMAL;
                if (c == tpp_pkg::CH_DOLLAR && !s_tlast) begin
                    mode_next = tpp_pkg::M_DOLLAR;
                end else begin
                    res_next[0] = tpp_pkg::byte_res(c);
                    cnt_next    = 2'd1;
                end
            end
        endcase

        // End of string closes any open spec
        if (s_tlast) begin
            fin = (mode_next != tpp_pkg::M_NORMAL) && (cnt_next == 2'd0) &&
                  spec_fires(delay_next, mand_next, rate_reg, baud_reg, noscreen_reg);
            if (fin) begin
                res_next[0] = tpp_pkg::delay_res(delay_next);
                cnt_next    = 2'd1;
            end
            mode_next  = tpp_pkg::M_NORMAL;
            delay_next = '0;
            mand_next  = 1'b0;
        end

        for (int k = 0; k < 3; k++) begin
            res_next[k].last_of_run   = (2'(k) == cnt_next - 2'd1);
            res_next[k].end_of_string = s_tlast;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            affected_reg <= 10'd1;
            flow_reg     <= 1'b0;
            rate_reg     <= 22'd0;
            baud_reg     <= 22'd0;
            noscreen_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tpp_pkg::CFG_AFFECTED: affected_reg <= cfg_data[9:0];
                tpp_pkg::CFG_FLOW:     flow_reg     <= cfg_data[0];
                tpp_pkg::CFG_RATE:     rate_reg     <= cfg_data;
                tpp_pkg::CFG_BAUD:     baud_reg     <= cfg_data;
                tpp_pkg::CFG_NOSCREEN: noscreen_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Parser state and buffer count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= tpp_pkg::M_NORMAL;
            delay_reg <= '0;
            mand_reg  <= 1'b0;
            cnt_reg   <= 2'd0;
        end else if (s_accept) begin
            mode_reg  <= mode_next;
            delay_reg <= delay_next;
            mand_reg  <= mand_next;
            cnt_reg   <= cnt_next;
        end else if (m_pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Result buffer payload: load on accept, shift towards the head on pop
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int k = 0; k < 3; k++) begin
                res_reg[k] <= res_next[k];
            end
        end else if (m_pop) begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

    // Checks
    `TPP_ASSERT_NOW(a_accept_drains, aclk, aresetn, s_accept,
        (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_pop))
    `TPP_ASSERT_NOW(a_tlast_at_tail, aclk, aresetn, m_tvalid, m_tlast == (cnt_reg == 2'd1))
    `TPP_ASSERT_NEXT(a_drain_empty, aclk, aresetn, m_pop && (cnt_reg == 2'd1) && !s_accept,
        !m_tvalid)
    `TPP_ASSERT_NEXT(a_string_end_clear, aclk, aresetn, s_accept && s_tlast,
        (mode_reg == tpp_pkg::M_NORMAL) && (delay_reg == '0) && !mand_reg)

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for terminfo_padding_parser_core: streams control strings
// through the core and checks every result item against its own parser predictor.
// Depends on tpp_pkg and the core RTL only.
module tb_top;

    localparam logic [7:0] CH_CLOSE    = 8'h3E;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         IDLE_PCT    = 35;
    localparam int         PHASE_ITEMS = 52;
    localparam int         MAX_REPORTS = 10;

    // how the closer_ahead flag is derived for a string
    typedef enum int {AHEAD_SCAN, AHEAD_ALL, AHEAD_NOISY} ahead_mode_t;
    typedef logic [7:0] octet_q_t[$];

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;  // [7:0] char_code
    logic        s_tlast   = 1'b0;
    logic        s_tuser   = 1'b0;  // closer_ahead
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;         // [7:0] out_char, [31:8] delay_tenths
    logic        m_tlast;
    logic [1:0]  m_tuser;         // [0] kind, [1] end_of_string
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [21:0] cfg_data  = '0;

    terminfo_padding_parser_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor state and its copy of the registers
    logic [2:0]      pmode       = tpp_pkg::M_NORMAL;
    tpp_pkg::delay_t acc_tenths  = '0;
    logic            pad_forced  = 1'b0;
    logic [9:0]      lines_cfg   = 10'd1;
    logic            xon_cfg     = 1'b0;
    logic [21:0]     rate_cfg    = '0;
    logic [21:0]     baud_cfg    = '0;
    logic            noscr_cfg   = 1'b1;

    tpp_pkg::res_t   step_res[$];
    tpp_pkg::res_t   expected_out[$];

    bit          calm        = 1'b0;
    int          errors      = 0;
    int          items_sent  = 0;
    int          results_ok  = 0;
    int          delays_due  = 0;
    int          cfg_sets    = 0;
    int          cycle_count = 0;

    // ---------------------------------------------------------------- predictor

    function automatic bit dec_digit(input logic [7:0] c);
        return c >= tpp_pkg::CH_ZERO && c <= tpp_pkg::CH_NINE;
    endfunction

    function automatic tpp_pkg::delay_t clamp(input logic [63:0] v);
        return (v > 64'(tpp_pkg::DELAY_MAX)) ? tpp_pkg::DELAY_MAX
                                             : v[tpp_pkg::DELAY_BITS-1:0];
    endfunction

    function automatic void emit(input logic k, input logic [7:0] c,
                                 input tpp_pkg::delay_t d);
        tpp_pkg::res_t r;
        logic [63:0]   wide;
        r = '0;
        wide = 64'(d);
        r.kind = k;
        r.out_char = c;
        r.delay_tenths = (wide > 64'hFF_FFFF) ? '1 : wide[tpp_pkg::OUT_BITS-1:0];
        if (k == tpp_pkg::KIND_DELAY)
            delays_due++;
        step_res.push_back(r);
    endfunction

    // end of a spec: request the delay if it is due
    function automatic void close_spec();
        if (pad_forced && acc_tenths != 0 && rate_cfg != 0 &&
            (noscr_cfg || baud_cfg >= rate_cfg))
            emit(tpp_pkg::KIND_DELAY, 8'h00, acc_tenths);
        acc_tenths = '0;
        pad_forced = 1'b0;
        pmode = tpp_pkg::M_NORMAL;
    endfunction

    function automatic void plain_byte(input logic [7:0] c, input logic last);
        if (c == tpp_pkg::CH_DOLLAR) begin
            if (last)
                emit(tpp_pkg::KIND_BYTE, tpp_pkg::CH_DOLLAR, '0);
            else
                pmode = tpp_pkg::M_DOLLAR;
        end else begin
            emit(tpp_pkg::KIND_BYTE, c, '0);
        end
    endfunction

    function automatic void modifier(input logic [7:0] c);
        if (c == tpp_pkg::CH_STAR) begin
            acc_tenths = clamp(64'(acc_tenths) * 64'(lines_cfg));
            pmode = tpp_pkg::M_MOD;
        end else if (c == tpp_pkg::CH_SLASH) begin
            pad_forced = 1'b1;
            pmode = tpp_pkg::M_MOD;
        end else begin
            close_spec();
        end
    endfunction

    // one accepted input item: queue the result items it must produce
    function automatic void parse_byte(input logic [7:0] c, input logic ahead,
                                       input logic last);
        step_res = {};
        case (pmode)
            tpp_pkg::M_DOLLAR: begin
                if (c == tpp_pkg::CH_OPEN) begin
                    if (last) begin
                        emit(tpp_pkg::KIND_BYTE, tpp_pkg::CH_DOLLAR, '0);
                        emit(tpp_pkg::KIND_BYTE, tpp_pkg::CH_OPEN, '0);
                        pmode = tpp_pkg::M_NORMAL;
                    end else begin
                        pmode = tpp_pkg::M_OPEN;
                    end
                end else begin
                    emit(tpp_pkg::KIND_BYTE, tpp_pkg::CH_DOLLAR, '0);
                    emit(tpp_pkg::KIND_BYTE, c, '0);
                    pmode = tpp_pkg::M_NORMAL;
                end
            end
            tpp_pkg::M_OPEN: begin
                if ((!dec_digit(c) && c != tpp_pkg::CH_DOT) || !ahead) begin
                    emit(tpp_pkg::KIND_BYTE, tpp_pkg::CH_DOLLAR, '0);
                    emit(tpp_pkg::KIND_BYTE, tpp_pkg::CH_OPEN, '0);
                    pmode = tpp_pkg::M_NORMAL;
                    plain_byte(c, last);
                end else begin
                    acc_tenths = '0;
                    pad_forced = !xon_cfg;
                    if (c == tpp_pkg::CH_DOT) begin
                        pmode = tpp_pkg::M_FRAC;
                    end else begin
                        acc_tenths = clamp(64'(c - tpp_pkg::CH_ZERO) * 64'(tpp_pkg::TEN));
                        pmode = tpp_pkg::M_INT;
                    end
                end
            end
            tpp_pkg::M_INT: begin
                if (dec_digit(c))
                    acc_tenths = clamp(64'(acc_tenths) * 64'(tpp_pkg::TEN) +
                                       64'(c - tpp_pkg::CH_ZERO) * 64'(tpp_pkg::TEN));
                else if (c == tpp_pkg::CH_DOT)
                    pmode = tpp_pkg::M_FRAC;
                else
                    modifier(c);
            end
            tpp_pkg::M_FRAC: begin
                if (dec_digit(c)) begin
                    acc_tenths = clamp(64'(acc_tenths) + 64'(c - tpp_pkg::CH_ZERO));
                    pmode = tpp_pkg::M_SKIP;
                end else begin
                    modifier(c);
                end
            end
            tpp_pkg::M_SKIP: begin
                if (!dec_digit(c))
                    modifier(c);
            end
            tpp_pkg::M_MOD: begin
                modifier(c);
            end
            default: begin
                pmode = tpp_pkg::M_NORMAL;
                plain_byte(c, last);
            end
        endcase
        // the string's last byte closes any open spec
        if (last) begin
            if (pmode != tpp_pkg::M_NORMAL)
                close_spec();
            pmode = tpp_pkg::M_NORMAL;
            acc_tenths = '0;
            pad_forced = 1'b0;
        end
        foreach (step_res[k]) begin
            step_res[k].last_of_run = (k == step_res.size() - 1);
            step_res[k].end_of_string = last;
            expected_out.push_back(step_res[k]);
        end
    endfunction

    function automatic void store_reg(input logic [2:0] idx, input logic [21:0] val);
        case (idx)
            tpp_pkg::CFG_AFFECTED: lines_cfg = val[9:0];
            tpp_pkg::CFG_FLOW:     xon_cfg   = val[0];
            tpp_pkg::CFG_RATE:     rate_cfg  = val;
            tpp_pkg::CFG_BAUD:     baud_cfg  = val;
            tpp_pkg::CFG_NOSCREEN: noscr_cfg = val[0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_error(input string what);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR at %0t ns: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input int n,
                                 input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
            flag_error($sformatf("result %0d %s: expected %0h, got %0h", n, name, want, got));
    endtask

    always @(posedge aclk) begin : result_monitor
        tpp_pkg::res_t want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_out.size() == 0) begin
                flag_error($sformatf("unexpected result: kind %0b data %0h last %0b",
                                     m_tuser[0], m_tdata, m_tlast));
            end else begin
                want = expected_out.pop_front();
                compare_field("kind", results_ok, 32'(want.kind), 32'(m_tuser[0]));
                compare_field("out_char", results_ok, 32'(want.out_char), 32'(m_tdata[7:0]));
                compare_field("delay_tenths", results_ok, 32'(want.delay_tenths),
                              32'(m_tdata[31:8]));
                compare_field("last_of_run", results_ok, 32'(want.last_of_run), 32'(m_tlast));
                compare_field("end_of_string", results_ok, 32'(want.end_of_string),
                              32'(m_tuser[1]));
            end
            results_ok++;
        end
    end

    // result side back-pressure
    always @(negedge aclk)
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped after %0d cycles", cycle_count);
        $display("terminfo_padding_parser_core test failed");
        $finish;
    end

    // ---------------------------------------------------------------- drivers

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_char(input logic [7:0] c, input logic ahead, input logic last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= ahead;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        parse_byte(c, ahead, last);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_string(input octet_q_t s, input ahead_mode_t how);
        logic ahead;
        for (int i = 0; i < s.size(); i++) begin
            ahead = (how == AHEAD_ALL);
            if (how != AHEAD_ALL)
                for (int j = i; j < s.size(); j++)
                    if (s[j] == CH_CLOSE)
                        ahead = 1'b1;
            if (how == AHEAD_NOISY && $urandom_range(0, 4) == 0)
                ahead = !ahead;
            send_char(s[i], ahead, i == s.size() - 1);
        end
    endtask

    // stop sending, let every expected result out, then allow for in-flight work
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // writes all five registers back to back; block must be idle
    task automatic configure(input logic [9:0] lines, input logic flow,
                             input logic [21:0] rate, input logic [21:0] baud,
                             input logic noscr);
        logic [21:0] vals[5];
        logic [2:0]  idx[5];
        vals = '{22'(lines), 22'(flow), rate, baud, 22'(noscr)};
        idx  = '{tpp_pkg::CFG_AFFECTED, tpp_pkg::CFG_FLOW, tpp_pkg::CFG_RATE,
                 tpp_pkg::CFG_BAUD, tpp_pkg::CFG_NOSCREEN};
        for (int k = 0; k < 5; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            do @(posedge aclk); while (!cfg_ready);
            store_reg(idx[k], vals[k]);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        cfg_sets++;
    endtask

    // ---------------------------------------------------------------- generators

    function automatic logic [7:0] rand_digit();
        return tpp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // punctuation-heavy byte for broken sequences
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0: return tpp_pkg::CH_DOLLAR;
            1: return tpp_pkg::CH_OPEN;
            2: return tpp_pkg::CH_DOT;
            3: return tpp_pkg::CH_STAR;
            4: return tpp_pkg::CH_SLASH;
            5: return CH_CLOSE;
            6: return rand_digit();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly well-formed specs wrapped in random text, the rest noise
    task automatic make_string(output octet_q_t s, output ahead_mode_t how);
        int nd;
        int pick;
        s = {};
        how = AHEAD_SCAN;
        if ($urandom_range(0, 99) < 25) begin
            how = AHEAD_NOISY;
            repeat ($urandom_range(1, 8)) s.push_back(noise_byte());
        end else begin
            repeat ($urandom_range(0, 3)) s.push_back(8'($urandom_range(0, 255)));
            s.push_back(tpp_pkg::CH_DOLLAR);
            s.push_back(tpp_pkg::CH_OPEN);
            nd = $urandom_range(0, 8);
            repeat (nd) s.push_back(rand_digit());
            if (nd == 0 || $urandom_range(0, 1)) begin
                s.push_back(tpp_pkg::CH_DOT);
                repeat ($urandom_range(0, 3)) s.push_back(rand_digit());
            end
            repeat ($urandom_range(0, 3))
                s.push_back($urandom_range(0, 1) ? tpp_pkg::CH_STAR : tpp_pkg::CH_SLASH);
            pick = $urandom_range(0, 9);
            if (pick >= 7)
                how = AHEAD_ALL;  // no closer byte follows, so flag it upstream-style
            if (pick < 7)
                s.push_back(CH_CLOSE);
            else if (pick < 9)
                s.push_back(8'($urandom_range(0, 255)));
            // pick 9: string ends inside the spec
            if (pick < 9)
                repeat ($urandom_range(0, 3)) s.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_strings(input int count);
        octet_q_t    s;
        ahead_mode_t how;
        int          start;
        start = items_sent;
        while (items_sent - start < count) begin
            make_string(s, how);
            send_string(s, how);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // defaults after reset: padding disabled, spec swallowed silently
    task automatic test_reset_defaults();
        octet_q_t s;
        s = {tpp_pkg::CH_DOLLAR, tpp_pkg::CH_OPEN, tpp_pkg::CH_ZERO + 8'd5, CH_CLOSE, 8'h7A};
        send_string(s, AHEAD_SCAN);
    endtask

    task automatic test_text_extremes();
        octet_q_t s;
        drain();
        configure(10'd3, 1'b0, 22'd9600, 22'd19200, 1'b0);
        s = {8'h00, 8'hFF};
        send_string(s, AHEAD_SCAN);
    endtask

    task automatic test_star_spec();
        octet_q_t s;
        s = {tpp_pkg::CH_DOLLAR, tpp_pkg::CH_OPEN, tpp_pkg::CH_ZERO + 8'd5,
             tpp_pkg::CH_STAR, CH_CLOSE};
        send_string(s, AHEAD_SCAN);
    endtask

    // dollar followed by another byte, dollar alone at the end, "$<" at the end
    task automatic test_dollar_cases();
        octet_q_t s;
        s = {tpp_pkg::CH_DOLLAR, 8'h78};
        send_string(s, AHEAD_SCAN);
        s = {tpp_pkg::CH_DOLLAR};
        send_string(s, AHEAD_SCAN);
        s = {tpp_pkg::CH_DOLLAR, tpp_pkg::CH_OPEN};
        send_string(s, AHEAD_SCAN);
    endtask

    // non-digit after "$<", and a digit with no closer ahead
    task automatic test_bad_starts();
        octet_q_t s;
        s = {tpp_pkg::CH_DOLLAR, tpp_pkg::CH_OPEN, 8'h71};
        send_string(s, AHEAD_SCAN);
        s = {tpp_pkg::CH_DOLLAR, tpp_pkg::CH_OPEN, tpp_pkg::CH_ZERO + 8'd3};
        send_string(s, AHEAD_SCAN);
    endtask

    // fraction with an extra digit, slash, and the string ending inside the spec
    task automatic test_open_spec_end();
        octet_q_t s;
        s = {tpp_pkg::CH_DOLLAR, tpp_pkg::CH_OPEN, tpp_pkg::CH_DOT,
             tpp_pkg::CH_ZERO + 8'd7, tpp_pkg::CH_ZERO + 8'd5, tpp_pkg::CH_SLASH};
        send_string(s, AHEAD_ALL);
    endtask

    task automatic test_saturation();
        drain();
        configure(10'd1023, 1'b0, 22'd1, 22'd0, 1'b1);
        run_strings(PHASE_ITEMS);
    endtask

    // xon/xoff on, star zeroes the delay, baud equal to rate at full scale
    task automatic test_flow_control();
        drain();
        configure(10'd0, 1'b1, 22'h3F_FFFF, 22'h3F_FFFF, 1'b0);
        run_strings(PHASE_ITEMS);
    endtask

    task automatic test_random_baud();
        drain();
        configure(10'($urandom_range(0, 1023)), 1'b0, 22'($urandom_range(1, 4194303)),
                  22'($urandom_range(0, 4194303)), 1'b0);
        run_strings(PHASE_ITEMS);
    endtask

    task automatic test_padding_off();
        drain();
        configure(10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)), 22'd0,
                  22'h3F_FFFF, 1'($urandom_range(0, 1)));
        run_strings(PHASE_ITEMS);
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_full_rate();
        drain();
        configure(10'd1, 1'b0, 22'd9600, 22'd38400, 1'b0);
        calm = 1'b1;
        run_strings(PHASE_ITEMS);
        drain();
        calm = 1'b0;
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_text_extremes();
        test_star_spec();
        test_dollar_cases();
        test_bad_starts();
        test_open_spec_end();
        test_saturation();
        test_flow_control();
        test_random_baud();
        test_padding_off();
        test_full_rate();

        s_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("Sent %0d bytes under %0d register settings; checked %0d results,",
                 items_sent, cfg_sets, results_ok);
        $display("%0d of them delay requests; %0d mismatches", delays_due, errors);
        if (errors == 0 && expected_out.size() == 0)
            $display("terminfo_padding_parser_core test passed");
        else
            $display("terminfo_padding_parser_core test failed");
        $finish;
    end

endmodule

/* terminfo_padding_parser_core.f */
+incdir+hdl
hdl/tpp_pkg.sv
hdl/terminfo_padding_parser_core.sv
tb/tb_top.sv
